// ===== hw/rtl/spr_pkg.sv =====
// Package for the servo pulse ramp generator: opcodes, register indexes,
// move modes, reset values and arithmetic widths. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package spr_pkg;

  // Fraction bits of an angle (1/16 degree).
  localparam int unsigned AngleFracBits = 4;

  // Field widths.
  localparam int unsigned PulseW  = 16;
  localparam int unsigned AngleW  = 13;
  localparam int unsigned StepW   = 12;
  localparam int unsigned TickW   = 16;
  localparam int unsigned CfgIdxW = 3;

  // Shared multiplier and divider widths.
  localparam int unsigned MulAW   = 28;
  localparam int unsigned MulBW   = 18;
  localparam int unsigned ProdW   = MulAW + MulBW;
  localparam int unsigned DvdW    = 41;
  localparam int unsigned DsrW    = 25;
  localparam int unsigned DivCntW = 6;

  typedef enum logic [1:0] {
    OP_SET    = 2'd0,
    OP_SMOOTH = 2'd1,
    OP_SOFT   = 2'd2,
    OP_TICK   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_SMOOTH = 2'd1,
    MODE_SOFT   = 2'd2
  } mode_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MIN_PULSE  = 3'd0,
    REG_MAX_PULSE  = 3'd1,
    REG_FULL_ANGLE = 3'd2,
    REG_RAMP_STEP  = 3'd3,
    REG_SOFT_TICKS = 3'd4
  } cfg_idx_t;

  localparam logic [PulseW-1:0] MinPulseRst   = 16'd500;
  localparam logic [PulseW-1:0] MaxPulseRst   = 16'd2500;
  localparam logic [AngleW-1:0] FullAngleRst  = 13'd5760;
  localparam logic [7:0]        RampStepRst   = 8'd3;
  localparam logic [7:0]        SoftTicksRst  = 8'd5;
  localparam logic [PulseW-1:0] PulseCountRst = 16'd1500;

endpackage
`default_nettype wire

// ===== hw/rtl/servo_pulse_ramp_generator.sv =====
// Servo pulse ramp generator top level: command decode, move sequencer,
// shared multiplier and shared bit-serial divider. Depends on spr_pkg.
//
// Each input word is one command (set, smooth ramp, soft start, or a 1 ms
// tick) and yields exactly one output word with the compare value and the
// moving flag. Words are processed one at a time on a single shared
// multiplier and a restoring divider that produces one quotient bit per
// cycle. A set or smooth ramp command runs one division for the compare
// value, a soft start two (one for the start angle and one for the compare
// value), a tick that takes a soft start step one, and any other tick none.
// With full_angle at zero the compare division is skipped. The next word
// is accepted in the cycle after the result is registered. The result stage
// waits while an earlier result is still held in the output register. The
// input is ready whenever the sequencer is idle, even while the previous
// result still waits in the output register.
`timescale 1ns / 1ps
`default_nettype none
module servo_pulse_ramp_generator
  import spr_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  // Command stream. tdata: opcode[1:0], goal angle[15:2],
  // ramp delay[31:16].
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic [31:0]         s_tdata,
  // Result stream. tdata: compare_value[15:0], moving[16], zero pad [23:17].
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic [23:0]              m_tdata,
  // Register write port.
  input  wire logic                cfg_we,
  input  wire logic [CfgIdxW-1:0]  cfg_addr,
  input  wire logic [15:0]         cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_SALD, S_SADIV, S_SASET, S_SNUM1, S_SNUM2, S_SNUM3,
    S_TOP, S_CLAMP, S_NSPAN, S_CLD, S_CDIV, S_CEND, S_FIN
  } state_t;

  state_t state;

  // Configuration registers.
  logic [PulseW-1:0] min_pulse_count;
  logic [PulseW-1:0] max_pulse_count;
  logic [AngleW-1:0] full_angle;
  logic [7:0]        ramp_step;
  logic [7:0]        soft_step_ticks;

  // Move state.
  logic [PulseW-1:0]       pulse_count;
  mode_t                   move_mode;
  logic [PulseW-1:0]       goal_count;
  logic [AngleW-1:0]       start_angle;
  logic signed [AngleW:0]  angle_span;
  logic [StepW-1:0]        step_index;
  logic [StepW-1:0]        step_total;
  logic [TickW-1:0]        tick_countdown;
  logic [TickW-1:0]        tick_reload;

  // Current command.
  op_t               cmd_op;
  logic [AngleW-1:0] cmd_angle;
  logic [TickW-1:0]  cmd_delay;

  // Conversion working registers.
  logic signed [MulAW-1:0] num;
  logic signed [ProdW-1:0] acc;
  logic [StepW-1:0]        mult;
  logic [DsrW-1:0]         top;
  logic [DsrW-1:0]         n_clamped;

  // Shared multiplier.
  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic signed [ProdW-1:0] prod;

  // Shared divider.
  logic [DvdW-1:0]    dvd;
  logic [DsrW:0]      rem;
  logic [DsrW-1:0]    divisor;
  logic [DivCntW-1:0] div_cnt;
  logic [DsrW:0]      rem_sh;
  logic [DsrW+1:0]    rem_diff;
  logic               div_last;

  // Combinational helpers.
  logic [PulseW-1:0]        span_c;
  logic signed [AngleW:0]   in_target;
  logic [AngleW-1:0]        in_angle;
  logic [AngleW-1:0]        sa_c;
  logic signed [AngleW:0]   aspan_c;
  logic [AngleW-1:0]        amag_c;
  logic [StepW-1:0]         st_raw;
  logic [StepW-1:0]         st_c;
  logic [TickW-1:0]         soft_reload_c;
  logic [PulseW:0]          ramp_stp;
  logic [PulseW-1:0]        ramp_next;
  logic [PulseW-1:0]        conv_res;

  assign span_c = (max_pulse_count >= min_pulse_count) ?
                  (max_pulse_count - min_pulse_count) : '0;

  // Clamp the incoming target to 0..full_angle.
  assign in_target = s_tdata[15:2];
  always_comb begin
    if (in_target < 0) begin
      in_angle = '0;
    end else if (in_target[AngleW-1:0] > full_angle) begin
      in_angle = full_angle;
    end else begin
      in_angle = in_target[AngleW-1:0];
    end
  end

  // Start angle from the divider quotient, with its span and step count.
  always_comb begin
    if (span_c == '0 || pulse_count <= min_pulse_count) begin
      sa_c = '0;
    end else if (dvd > DvdW'(full_angle)) begin
      sa_c = full_angle;
    end else begin
      sa_c = dvd[AngleW-1:0];
    end
    aspan_c = $signed({1'b0, cmd_angle}) - $signed({1'b0, sa_c});
    amag_c  = aspan_c[AngleW] ? AngleW'(-aspan_c) : aspan_c[AngleW-1:0];
    st_raw  = StepW'({amag_c >> AngleFracBits, 2'b00});
    st_c    = (st_raw == '0) ? StepW'(1) : st_raw;
    soft_reload_c = (soft_step_ticks == '0) ? TickW'(1) : TickW'(soft_step_ticks);
  end

  // One smooth ramp step toward the goal, stopping exactly on it.
  always_comb begin
    ramp_stp = (ramp_step == '0) ? (PulseW + 1)'(1) : (PulseW + 1)'(ramp_step);
    if (pulse_count < goal_count) begin
      ramp_next = ((PulseW + 1)'(goal_count - pulse_count) <= ramp_stp) ? goal_count :
                  PulseW'({1'b0, pulse_count} + ramp_stp);
    end else begin
      ramp_next = ((PulseW + 1)'(pulse_count - goal_count) <= ramp_stp) ? goal_count :
                  PulseW'({1'b0, pulse_count} - ramp_stp);
    end
  end

  assign conv_res = min_pulse_count + dvd[PulseW-1:0];

  // Multiplier operand selection by sequencer step.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_DEC: begin
        mul_a = MulAW'(pulse_count - min_pulse_count);
        mul_b = MulBW'(full_angle);
      end
      S_SNUM1: begin
        mul_a = MulAW'(start_angle);
        mul_b = MulBW'(step_total);
      end
      S_SNUM2: begin
        mul_a = MulAW'(angle_span);
        mul_b = MulBW'(step_index);
      end
      S_TOP: begin
        mul_a = MulAW'(full_angle);
        mul_b = MulBW'(mult);
      end
      S_NSPAN: begin
        mul_a = MulAW'(n_clamped);
        mul_b = MulBW'(span_c);
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  // Restoring divider step: one quotient bit per cycle.
  assign rem_sh   = {rem[DsrW-1:0], dvd[DvdW-1]};
  assign rem_diff = {1'b0, rem_sh} - {2'b00, divisor};
  assign div_last = (div_cnt == DivCntW'(DvdW - 1));

  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;

    if (state == S_SADIV || state == S_CDIV) begin
      if (!rem_diff[DsrW+1]) begin
        rem <= rem_diff[DsrW:0];
        dvd <= {dvd[DvdW-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        dvd <= {dvd[DvdW-2:0], 1'b0};
      end
      div_cnt <= div_cnt + 1'b1;
    end

    if (rst) begin
      state           <= S_IDLE;
      m_tvalid        <= 1'b0;
      m_tdata         <= '0;
      min_pulse_count <= MinPulseRst;
      max_pulse_count <= MaxPulseRst;
      full_angle      <= FullAngleRst;
      ramp_step       <= RampStepRst;
      soft_step_ticks <= SoftTicksRst;
      pulse_count     <= PulseCountRst;
      move_mode       <= MODE_IDLE;
      goal_count      <= '0;
      start_angle     <= '0;
      angle_span      <= '0;
      step_index      <= '0;
      step_total      <= StepW'(1);
      tick_countdown  <= '0;
      tick_reload     <= '0;
    end else begin
      // Register writes.
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_MIN_PULSE:  min_pulse_count <= cfg_data;
          REG_MAX_PULSE:  max_pulse_count <= cfg_data;
          REG_FULL_ANGLE: full_angle      <= cfg_data[AngleW-1:0];
          REG_RAMP_STEP:  ramp_step       <= cfg_data[7:0];
          REG_SOFT_TICKS: soft_step_ticks <= cfg_data[7:0];
          default: ;
        endcase
      end

      // The result stage reloads the output register itself.
      if (m_tvalid && m_tready && state != S_FIN) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            cmd_op    <= op_t'(s_tdata[1:0]);
            cmd_angle <= in_angle;
            cmd_delay <= s_tdata[31:16];
            state     <= S_DEC;
          end
        end
        S_DEC: begin
          unique case (cmd_op)
            OP_SET, OP_SMOOTH: begin
              num   <= MulAW'(cmd_angle);
              mult  <= StepW'(1);
              state <= S_TOP;
            end
            OP_SOFT: begin
              state <= S_SALD;
            end
            default: begin
              if (move_mode == MODE_IDLE) begin
                state <= S_FIN;
              end else if (tick_countdown > TickW'(1)) begin
                tick_countdown <= tick_countdown - 1'b1;
                state          <= S_FIN;
              end else begin
                tick_countdown <= tick_reload;
                if (move_mode == MODE_SMOOTH) begin
                  pulse_count <= ramp_next;
                  if (ramp_next == goal_count) begin
                    move_mode <= MODE_IDLE;
                  end
                  state <= S_FIN;
                end else begin
                  if (step_index < step_total) begin
                    step_index <= step_index + 1'b1;
                  end
                  state <= S_SNUM1;
                end
              end
            end
          endcase
        end
        S_SALD: begin
          dvd     <= DvdW'(prod);
          rem     <= '0;
          divisor <= DsrW'(span_c);
          div_cnt <= '0;
          state   <= S_SADIV;
        end
        S_SADIV: begin
          if (div_last) begin
            state <= S_SASET;
          end
        end
        S_SASET: begin
          start_angle    <= sa_c;
          angle_span     <= aspan_c;
          step_total     <= st_c;
          step_index     <= '0;
          tick_reload    <= soft_reload_c;
          tick_countdown <= soft_reload_c;
          state          <= S_SNUM1;
        end
        S_SNUM1: begin
          state <= S_SNUM2;
        end
        S_SNUM2: begin
          acc   <= prod;
          state <= S_SNUM3;
        end
        S_SNUM3: begin
          num   <= MulAW'(acc + prod);
          mult  <= step_total;
          state <= S_TOP;
        end
        S_TOP: begin
          state <= S_CLAMP;
        end
        S_CLAMP: begin
          // Saturate the rational angle to 0..full_angle*mult.
          top <= prod[DsrW-1:0];
          if (num < 0) begin
            n_clamped <= '0;
          end else if (num[MulAW-2:0] > (MulAW - 1)'(prod[DsrW-1:0])) begin
            n_clamped <= prod[DsrW-1:0];
          end else begin
            n_clamped <= num[DsrW-1:0];
          end
          if (full_angle == '0) begin
            dvd   <= '0;
            state <= S_CEND;
          end else begin
            state <= S_NSPAN;
          end
        end
        S_NSPAN: begin
          state <= S_CLD;
        end
        S_CLD: begin
          dvd     <= DvdW'(prod);
          rem     <= '0;
          divisor <= top;
          div_cnt <= '0;
          state   <= S_CDIV;
        end
        S_CDIV: begin
          if (div_last) begin
            state <= S_CEND;
          end
        end
        S_CEND: begin
          unique case (cmd_op)
            OP_SET: begin
              pulse_count <= conv_res;
              move_mode   <= MODE_IDLE;
            end
            OP_SMOOTH: begin
              goal_count     <= conv_res;
              tick_reload    <= (cmd_delay == '0) ? TickW'(1) : cmd_delay;
              tick_countdown <= (cmd_delay == '0) ? TickW'(1) : cmd_delay;
              move_mode      <= (pulse_count == conv_res) ? MODE_IDLE : MODE_SMOOTH;
            end
            default: begin
              pulse_count <= conv_res;
              move_mode   <= (step_index >= step_total) ? MODE_IDLE : MODE_SOFT;
            end
          endcase
          state <= S_FIN;
        end
        S_FIN: begin
          // Wait for the output register to free up.
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {7'b0, (move_mode != MODE_IDLE), pulse_count};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Only one word is in flight at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("command accepted while busy");

  // The compare division never divides by zero.
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == S_CDIV |-> divisor != '0)
    else $error("compare division by zero");

  // A soft move never steps past its last step.
  a_soft_index: assert property (@(posedge clk) disable iff (rst)
    move_mode == MODE_SOFT |-> step_index <= step_total)
    else $error("soft start step index overran");

  // A smooth move always has somewhere to go.
  a_smooth_goal: assert property (@(posedge clk) disable iff (rst)
    move_mode == MODE_SMOOTH && state == S_IDLE |-> pulse_count != goal_count)
    else $error("smooth move stalled on its goal");

endmodule
`default_nettype wire

// ===== tb/tb_servo_pulse_ramp_generator.sv =====
// Self-checking testbench for the servo pulse ramp generator: a command driver,
// a result monitor and a command-level model of the compare-value sequencer.
// Depends on spr_pkg and the servo_pulse_ramp_generator RTL.
`timescale 1ns / 1ps
module tb_servo_pulse_ramp_generator;
  import spr_pkg::*;

  localparam int unsigned CycleLimit = 2000000;

  typedef struct packed {
    logic [15:0] delay;
    logic [13:0] target;
    op_t         op;
  } cmd_t;

  typedef struct {
    logic [15:0] count;
    logic        moving;
  } servo_out_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [31:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_addr = '0;
  logic [15:0] cfg_data = '0;
  logic in_fire = 1'b0;

  servo_pulse_ramp_generator uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Model registers and state.
  longint unsigned mdl_min, mdl_max, mdl_full, mdl_ramp, mdl_soft_ticks;
  longint unsigned pulse, goal, start_ang, step_idx, step_tot, countdown, reload;
  longint angle_delta;
  mode_t mode;

  cmd_t pending_cmds[$];
  servo_out_t expected_outs[$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int errors = 0;
  int cycles = 0;

  function automatic longint unsigned pulse_span();
    return (mdl_max >= mdl_min) ? mdl_max - mdl_min : 0;
  endfunction

  // Compare count for the rational angle num/mult.
  function automatic longint unsigned angle_to_count(longint num, longint unsigned mult);
    longint unsigned top, n;
    if (mdl_full == 0 || mult == 0) return mdl_min & 16'hFFFF;
    top = mdl_full * mult;
    if (num < 0) n = 0;
    else if (longint'(num) > longint'(top)) n = top;
    else n = num;
    return (mdl_min + (n * pulse_span()) / top) & 16'hFFFF;
  endfunction

  function automatic void write_soft_count();
    pulse = angle_to_count(longint'(start_ang * step_tot) + angle_delta * longint'(step_idx),
                           step_tot);
  endfunction

  // Advance the model by one command and queue the resulting word.
  function automatic void predict_command(cmd_t c);
    longint tsig;
    longint unsigned tgt, mag, st, stp;
    servo_out_t r;
    tsig = longint'(signed'(c.target));
    tgt = (tsig < 0) ? 0 : (tsig > longint'(mdl_full)) ? mdl_full : tsig;
    case (c.op)
      OP_SET: begin
        pulse = angle_to_count(tgt, 1);
        mode = MODE_IDLE;
      end
      OP_SMOOTH: begin
        goal = angle_to_count(tgt, 1);
        reload = (c.delay == 0) ? 1 : c.delay;
        countdown = reload;
        mode = (pulse == goal) ? MODE_IDLE : MODE_SMOOTH;
      end
      OP_SOFT: begin
        if (pulse_span() == 0 || pulse <= mdl_min) start_ang = 0;
        else begin
          start_ang = ((pulse - mdl_min) * mdl_full) / pulse_span();
          if (start_ang > mdl_full) start_ang = mdl_full;
        end
        angle_delta = longint'(tgt) - longint'(start_ang);
        mag = (angle_delta < 0) ? -angle_delta : angle_delta;
        st = (mag >> AngleFracBits) * 4;
        if (st < 1) st = 1;
        if (st > 4095) st = 4095;
        step_tot = st;
        step_idx = 0;
        reload = (mdl_soft_ticks == 0) ? 1 : mdl_soft_ticks;
        countdown = reload;
        write_soft_count();
        mode = MODE_SOFT;
      end
      default: begin
        if (mode != MODE_IDLE) begin
          if (countdown > 1) countdown--;
          else begin
            countdown = reload;
            if (mode == MODE_SMOOTH) begin
              stp = (mdl_ramp == 0) ? 1 : mdl_ramp;
              if (pulse < goal) pulse = (goal - pulse <= stp) ? goal : pulse + stp;
              else pulse = (pulse - goal <= stp) ? goal : pulse - stp;
              if (pulse == goal) mode = MODE_IDLE;
            end else begin
              if (step_idx < step_tot) step_idx++;
              write_soft_count();
              if (step_idx >= step_tot) mode = MODE_IDLE;
            end
          end
        end
      end
    endcase
    r.count = pulse[15:0];
    r.moving = (mode != MODE_IDLE);
    expected_outs.push_back(r);
  endfunction

  // Records whether a command word was taken at this rising edge.
  always @(posedge clk) begin
    in_fire <= !rst && s_tvalid && s_tready;
  end

  // Driver: presents queued commands at the falling edge.
  always @(negedge clk) begin
    if (!rst) begin
      if (in_fire) begin
        // The accepted word was taken at the last rising edge.
        predict_command(cmd_t'(s_tdata));
        void'(pending_cmds.pop_front());
      end
      if (s_tvalid && !in_fire) begin
        // Hold the waiting word unchanged.
      end else if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        s_tvalid <= 1'b1;
        s_tdata <= pending_cmds[0];
      end else begin
        s_tvalid <= 1'b0;
      end
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: checks each result word at the rising edge.
  always @(posedge clk) begin
    servo_out_t w;
    cycles <= cycles + 1;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_outs.size() == 0) begin
        $error("result word with no command pending: %h", m_tdata);
        errors++;
      end else begin
        w = expected_outs.pop_front();
        if (m_tdata[15:0] !== w.count) begin
          $error("compare_value expected %0d actual %0d", w.count, m_tdata[15:0]);
          errors++;
        end
        if (m_tdata[16] !== w.moving) begin
          $error("moving expected %0d actual %0d", w.moving, m_tdata[16]);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles >= CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic void add_cmd(op_t op, logic [13:0] tgt, logic [15:0] dly);
    cmd_t c;
    c.op = op;
    c.target = tgt;
    c.delay = dly;
    pending_cmds.push_back(c);
  endfunction

  // Waits until every command is done and a slow command could have finished.
  task automatic drain();
    while (pending_cmds.size() > 0 || s_tvalid || expected_outs.size() > 0)
      @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MIN_PULSE:  mdl_min = val;
      REG_MAX_PULSE:  mdl_max = val;
      REG_FULL_ANGLE: mdl_full = val[12:0];
      REG_RAMP_STEP:  mdl_ramp = val[7:0];
      default:        mdl_soft_ticks = val[7:0];
    endcase
  endtask

  // Mostly moves followed by ticks to see them through, with noise mixed in.
  task automatic random_phase(int n);
    int k, sel, j;
    logic [13:0] tgt;
    k = 0;
    while (k < n) begin
      sel = $urandom_range(9);
      tgt = (sel < 7) ? 14'($urandom_range(6000)) : 14'($urandom);
      if (sel < 3) begin
        add_cmd(OP_SMOOTH, tgt, 16'($urandom_range(3)));
        for (j = 0; j < $urandom_range(30); j++) add_cmd(OP_TICK, 14'($urandom), 16'($urandom));
        k += 1 + j;
      end else if (sel < 6) begin
        add_cmd(OP_SOFT, tgt, 16'($urandom));
        for (j = 0; j < $urandom_range(40); j++) add_cmd(OP_TICK, 14'($urandom), 16'($urandom));
        k += 1 + j;
      end else if (sel < 7) begin
        add_cmd(OP_SMOOTH, tgt, 16'($urandom));
        k++;
      end else begin
        add_cmd(op_t'($urandom_range(3)), tgt, 16'($urandom));
        k++;
      end
    end
  endtask

  initial begin
    mdl_min = MinPulseRst; mdl_max = MaxPulseRst; mdl_full = FullAngleRst;
    mdl_ramp = RampStepRst; mdl_soft_ticks = SoftTicksRst;
    pulse = PulseCountRst; mode = MODE_IDLE; goal = 0; start_ang = 0;
    angle_delta = 0; step_idx = 0; step_tot = 1; countdown = 0; reload = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: extremes, every opcode, idle ticks, aborts.
    send_idle_pct = 9; recv_idle_pct = 77;
    add_cmd(OP_TICK, 14'h0, 16'h0);
    add_cmd(OP_SET, 14'h2000, 16'hFFFF);
    add_cmd(OP_SET, 14'h1FFF, 16'h0);
    add_cmd(OP_SET, 14'd2880, 16'h0);
    add_cmd(OP_SMOOTH, 14'd2880, 16'h0);
    add_cmd(OP_SMOOTH, 14'd3000, 16'h0);
    repeat (4) add_cmd(OP_TICK, 14'h3FFF, 16'hFFFF);
    add_cmd(OP_SMOOTH, 14'h0, 16'd2);
    repeat (3) add_cmd(OP_TICK, 14'h0, 16'h0);
    add_cmd(OP_SOFT, 14'd5760, 16'h0);
    repeat (6) add_cmd(OP_TICK, 14'h0, 16'h0);
    add_cmd(OP_SOFT, 14'h3000, 16'h0);
    add_cmd(OP_TICK, 14'h0, 16'h0);
    drain();

    // Extremes and odd settings of the registers.
    write_reg(REG_MIN_PULSE, 16'hFFFF);
    write_reg(REG_MAX_PULSE, 16'h0);
    write_reg(REG_FULL_ANGLE, 16'd8191);
    write_reg(REG_RAMP_STEP, 16'd0);
    write_reg(REG_SOFT_TICKS, 16'd0);
    random_phase(60);
    drain();
    write_reg(REG_MIN_PULSE, 16'd0);
    write_reg(REG_MAX_PULSE, 16'hFFFF);
    write_reg(REG_RAMP_STEP, 16'd255);
    write_reg(REG_SOFT_TICKS, 16'd1);
    random_phase(400);
    drain();

    send_idle_pct = 77; recv_idle_pct = 9;
    write_reg(REG_FULL_ANGLE, 16'd16);
    write_reg(REG_MIN_PULSE, 16'd1000);
    write_reg(REG_MAX_PULSE, 16'd2000);
    write_reg(REG_RAMP_STEP, 16'd7);
    write_reg(REG_SOFT_TICKS, 16'd2);
    random_phase(400);
    drain();

    send_idle_pct = 0; recv_idle_pct = 0;
    write_reg(REG_FULL_ANGLE, 16'd0);
    random_phase(60);
    drain();
    write_reg(REG_MIN_PULSE, 16'd500);
    write_reg(REG_MAX_PULSE, 16'd2500);
    write_reg(REG_FULL_ANGLE, 16'd5760);
    write_reg(REG_RAMP_STEP, 16'd20);
    write_reg(REG_SOFT_TICKS, 16'd1);
    random_phase(900);
    drain();

    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule
